@@ sv/png_ru_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_ru_pkg
// shared types, register indexes and the paeth predictor for the row unfilter
// ----------------------------------------------------------------------------
package png_ru_pkg;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_BYTES_PER_PIXEL = 2'd1,
    REG_IMAGE_ROWS      = 2'd2
  } cfg_reg_t;

  localparam int WIDTH_BITS = 12;
  localparam int BPP_BITS   = 3;
  localparam int ROWS_BITS  = 16;
  localparam int CFG_BITS   = 16;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    pa = 11'(signed'({3'b000, b})) - 11'(signed'({3'b000, c}));
    pb = 11'(signed'({3'b000, a})) - 11'(signed'({3'b000, c}));
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

endpackage

@@ sv/png_row_unfilter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_unit
// png scanline filter reconstruction (none, sub, up, average, paeth)
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes the inflated scanline stream, one byte per word. The first word
//   of each row is the filter type, the row's data bytes follow it.
//   m_* gives one reconstructed byte per data word; tlast marks the last
//   byte of a row, tuser[0] the last byte of the image, tuser[1] a filter
//   type above 4 (that word carries zero data and the row is taken as none).
//   Filter type words in range give no output word.
//   cfg_* writes image_width, bytes_per_pixel and image_rows by index;
//   cfg_ready is always high; the user must make writes only while the stream
//   is idle, and the block itself does not enforce this. One word per cycle
//   moves while m_tready stays high; a data byte passes the input register
//   (with the line store read), then the result register. The line store is
//   one write and one read port.
// Reset:
//   rst clears the pipeline, counters and pixel histories; the block then
//   expects a filter type word. The line store is not cleared.
// Stalls:
//   while m_tready is low a pending result holds, the input register fills
//   behind it, and s_tready drops only once both are full.
// ----------------------------------------------------------------------------
module png_row_unfilter_unit #(
  parameter int MAX_ROW_BYTES = 8192,
  parameter int MAX_BPP       = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // raw_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // pixel_byte
  output logic                            m_tlast,   // last_in_row
  output logic [1:0]                      m_tuser,   // last_of_image, bad_filter
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [png_ru_pkg::CFG_BITS-1:0] cfg_data
);
  import png_ru_pkg::*;

  localparam int CW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int SDW = $clog2(MAX_ROW_BYTES + 1);
  localparam int BW  = $clog2(MAX_BPP + 1);
  localparam int SW  = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
  localparam int PW  = WIDTH_BITS + BW;

  // configuration
  logic [WIDTH_BITS-1:0] image_width;
  logic [BPP_BITS-1:0]   bytes_per_pixel;
  logic [ROWS_BITS-1:0]  image_rows;

  logic [WIDTH_BITS-1:0] width_eff;
  logic [BW-1:0]         bpp_eff;
  logic [ROWS_BITS-1:0]  rows_eff;
  logic [PW-1:0]         row_prod;
  logic [SDW-1:0]        stride;
  logic [SW-1:0]         bpp_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_BITS'(1);
      bytes_per_pixel <= BPP_BITS'(1);
      image_rows      <= ROWS_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[WIDTH_BITS-1:0];
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_BITS-1:0];
        REG_IMAGE_ROWS:      image_rows      <= cfg_data[ROWS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = (image_width == '0) ? WIDTH_BITS'(1) : image_width;
    rows_eff  = (image_rows == '0) ? ROWS_BITS'(1) : image_rows;
    if (bytes_per_pixel == '0) begin
      bpp_eff = BW'(1);
    end else if (32'(bytes_per_pixel) > 32'(MAX_BPP)) begin
      bpp_eff = BW'(MAX_BPP);
    end else begin
      bpp_eff = BW'(bytes_per_pixel);
    end
    bpp_idx  = SW'(bpp_eff - BW'(1));
    row_prod = PW'(width_eff) * PW'(bpp_eff);
    if (32'(row_prod) > 32'(MAX_ROW_BYTES)) begin
      stride = SDW'(MAX_ROW_BYTES);
    end else begin
      stride = SDW'(row_prod);
    end
  end

  // stream state
  logic [CW-1:0]        column_count;
  logic [ROWS_BITS-1:0] row_count;
  filter_t              current_filter;
  logic                 awaiting_filter_byte;
  logic                 on_first_row;
  logic [SW-1:0]        slot_cnt [MAX_BPP];

  // input register
  logic          s1_valid;
  logic          s1_bad;
  logic [7:0]    s1_byte;
  logic [CW-1:0] s1_x;
  logic [SW-1:0] s1_slot;
  logic          s1_has_left;
  logic          s1_first_row;
  filter_t       s1_filter;
  logic          s1_row_end;
  logic          s1_img_end;
  logic [7:0]    s1_above;

  // result register
  logic       m_valid;
  logic [7:0] m_byte;
  logic       m_row_end;
  logic       m_img_end;
  logic       m_bad;

  logic [7:0] left_history   [MAX_BPP];
  logic [7:0] upleft_history [MAX_BPP];
  logic [7:0] previous_row   [MAX_ROW_BYTES];

  logic           s1_drain;
  logic           accept;
  logic           is_data;
  logic [SDW-1:0] x_inc;
  logic           row_end;
  logic [ROWS_BITS-1:0] row_count_next;
  logic           img_end;
  logic           wr_en;

  assign s1_drain = s1_valid && (!m_valid || m_tready);
  assign s_tready = !s1_valid || s1_drain;
  assign accept   = s_tvalid && s_tready;
  assign is_data  = !awaiting_filter_byte;
  assign x_inc    = SDW'(column_count) + SDW'(1);
  assign row_end  = (x_inc >= stride);
  assign row_count_next = row_count + ROWS_BITS'(1);
  assign img_end  = (row_count_next >= rows_eff);
  assign wr_en    = s1_drain && !s1_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count         <= '0;
      row_count            <= '0;
      current_filter       <= FILT_NONE;
      awaiting_filter_byte <= 1'b1;
      on_first_row         <= 1'b1;
      for (int k = 0; k < MAX_BPP; k++) begin
        slot_cnt[k] <= '0;
      end
    end else if (accept) begin
      if (!is_data) begin
        awaiting_filter_byte <= 1'b0;
        column_count         <= '0;
        for (int k = 0; k < MAX_BPP; k++) begin
          slot_cnt[k] <= '0;
        end
        if (s_tdata > {5'b00000, FILT_PAETH}) begin
          current_filter <= FILT_NONE;
        end else begin
          current_filter <= filter_t'(s_tdata[2:0]);
        end
      end else if (row_end) begin
        column_count         <= '0;
        awaiting_filter_byte <= 1'b1;
        for (int k = 0; k < MAX_BPP; k++) begin
          slot_cnt[k] <= '0;
        end
        if (img_end) begin
          row_count    <= '0;
          on_first_row <= 1'b1;
        end else begin
          row_count    <= row_count_next;
          on_first_row <= 1'b0;
        end
      end else begin
        column_count <= column_count + CW'(1);
        for (int k = 0; k < MAX_BPP; k++) begin
          slot_cnt[k] <= (slot_cnt[k] == SW'(k)) ? '0 : slot_cnt[k] + SW'(1);
        end
      end
    end
  end

  // input register, valid only for words that give a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_data || (s_tdata > {5'b00000, FILT_PAETH});
    end else if (s1_drain) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bad       <= !is_data;
      s1_byte      <= s_tdata;
      s1_x         <= column_count;
      s1_slot      <= slot_cnt[bpp_idx];
      s1_has_left  <= (SDW'(column_count) >= SDW'(bpp_eff));
      s1_first_row <= on_first_row;
      s1_filter    <= current_filter;
      s1_row_end   <= row_end;
      s1_img_end   <= row_end && img_end;
    end
  end

  // reconstruction
  logic [7:0] left_b;
  logic [7:0] above_b;
  logic [7:0] upleft_b;
  logic [8:0] avg_sum;
  logic [7:0] pred;
  logic [7:0] recon;

  always_comb begin
    left_b   = s1_has_left ? left_history[s1_slot] : 8'd0;
    above_b  = s1_first_row ? 8'd0 : s1_above;
    upleft_b = (!s1_first_row && s1_has_left) ? upleft_history[s1_slot] : 8'd0;
    avg_sum  = {1'b0, left_b} + {1'b0, above_b};
    case (s1_filter)
      FILT_SUB:   pred = left_b;
      FILT_UP:    pred = above_b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(left_b, above_b, upleft_b);
      default:    pred = 8'd0;
    endcase
    recon = s1_byte + pred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_BPP; k++) begin
        left_history[k]   <= 8'd0;
        upleft_history[k] <= 8'd0;
      end
    end else if (wr_en) begin
      left_history[s1_slot]   <= recon;
      upleft_history[s1_slot] <= above_b;
    end
  end

  // line store, read with the accepted word, written as the result leaves
  always_ff @(posedge clk) begin
    if (wr_en) begin
      previous_row[s1_x] <= recon;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en && (s1_x == column_count)) begin
        s1_above <= recon;
      end else begin
        s1_above <= previous_row[column_count];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s1_drain) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_drain) begin
      m_byte    <= s1_bad ? 8'd0 : recon;
      m_row_end <= !s1_bad && s1_row_end;
      m_img_end <= !s1_bad && s1_img_end;
      m_bad     <= s1_bad;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = m_byte;
  assign m_tlast  = m_row_end;
  assign m_tuser  = {m_bad, m_img_end};

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for png_row_unfilter_unit
// ----------------------------------------------------------------------------
// Feeds scanline streams (filter type word, then the row's data words) under
// many image geometries, including out-of-range and saturating settings,
// bad filter types, and a mid-image change of the row total. A scoreboard
// keeps its own line store and pixel histories, rebuilds every byte and
// compares each output word field by field. Both stream sides idle at random,
// and once the output side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import png_ru_pkg::*;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam logic [7:0] FILT_BAD_MIN = 8'd5;
  localparam int         STORE_BYTES  = 8192;
  localparam int         PIX_MAX      = 4;
  localparam int         CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_last;
    logic       image_last;
    logic       bad;
  } pixel_word_t;

  class unfilter_scoreboard;
    logic [11:0]   width_reg;
    logic [2:0]    bpp_reg;
    logic [15:0]   rows_reg;
    logic [7:0]    line_mem [STORE_BYTES];
    logic [7:0]    left_hist [PIX_MAX];
    logic [7:0]    upleft_hist [PIX_MAX];
    int unsigned   col;
    logic [15:0]   row_num;
    filter_t       filt;
    bit            want_filter;
    bit            first_row;
    pixel_word_t   pixel_q [$];
    int            mismatches;

    function new();
      width_reg   = 12'd1;
      bpp_reg     = 3'd1;
      rows_reg    = 16'd1;
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      foreach (left_hist[i]) begin
        left_hist[i]   = 8'h00;
        upleft_hist[i] = 8'h00;
      end
      col         = 0;
      row_num     = 16'd0;
      filt        = FILT_NONE;
      want_filter = 1'b1;
      first_row   = 1'b1;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_IMAGE_WIDTH:     width_reg = val[11:0];
        REG_BYTES_PER_PIXEL: bpp_reg   = val[2:0];
        REG_IMAGE_ROWS:      rows_reg  = val;
        default: ;
      endcase
    endfunction

    function int unsigned bpp_eff();
      if (bpp_reg == 3'd0) return 1;
      if (32'(bpp_reg) > PIX_MAX) return PIX_MAX;
      return 32'(bpp_reg);
    endfunction

    function int unsigned row_len();
      int unsigned s;
      s = ((width_reg == 12'd0) ? 1 : 32'(width_reg)) * bpp_eff();
      return (s > STORE_BYTES) ? STORE_BYTES : s;
    endfunction

    function int unsigned rows_total();
      return (rows_reg == 16'd0) ? 1 : 32'(rows_reg);
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int est;
      int da;
      int db;
      int dc;
      est = int'(a) + int'(b) - int'(c);
      da  = est - int'(a);
      db  = est - int'(b);
      dc  = est - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      return (db <= dc) ? b : c;
    endfunction

    // one accepted input word; queues the output word it causes, if any
    function void note_byte(logic [7:0] b);
      int unsigned bpp;
      int unsigned x;
      int unsigned slot;
      logic [7:0]  l;
      logic [7:0]  u;
      logic [7:0]  ul;
      logic [7:0]  pred;
      logic [7:0]  val;
      pixel_word_t w;
      if (want_filter) begin
        want_filter = 1'b0;
        col         = 0;
        if (b > 8'd4) begin
          filt = FILT_NONE;
          w    = '{pixel: 8'h00, row_last: 1'b0, image_last: 1'b0, bad: 1'b1};
          pixel_q.push_back(w);
        end else begin
          filt = filter_t'(b[2:0]);
        end
        return;
      end
      bpp  = bpp_eff();
      x    = col;
      slot = x % bpp;
      l    = (x >= bpp) ? left_hist[slot] : 8'h00;
      u    = first_row ? 8'h00 : line_mem[x];
      ul   = (!first_row && x >= bpp) ? upleft_hist[slot] : 8'h00;
      case (filt)
        FILT_SUB:   pred = l;
        FILT_UP:    pred = u;
        FILT_AVG:   pred = 8'((9'(l) + 9'(u)) >> 1);
        FILT_PAETH: pred = paeth_pick(l, u, ul);
        default:    pred = 8'h00;
      endcase
      val               = b + pred;
      upleft_hist[slot] = u;
      left_hist[slot]   = val;
      line_mem[x]       = val;
      w = '{pixel: val, row_last: 1'b0, image_last: 1'b0, bad: 1'b0};
      if (x + 1 >= row_len()) begin
        w.row_last  = 1'b1;
        col         = 0;
        want_filter = 1'b1;
        row_num     = row_num + 16'd1;
        if (32'(row_num) >= rows_total()) begin
          w.image_last = 1'b1;
          row_num      = 16'd0;
          first_row    = 1'b1;
        end else begin
          first_row = 1'b0;
        end
      end else begin
        col = x + 1;
      end
      pixel_q.push_back(w);
    endfunction

    function void check_word(logic [7:0] pixel, logic row_last, logic image_last,
                             logic bad);
      pixel_word_t want;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pixel %02h last %0b image %0b bad %0b",
                   pixel, row_last, image_last, bad);
        return;
      end
      want = pixel_q.pop_front();
      if (pixel !== want.pixel || row_last !== want.row_last ||
          image_last !== want.image_last || bad !== want.bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                   want.pixel, want.row_last, want.image_last, want.bad,
                   pixel, row_last, image_last, bad);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;  // raw_byte
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;            // pixel_byte
  logic        m_tlast;            // last_in_row
  logic [1:0]  m_tuser;            // last_of_image, bad_filter
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data  = 16'h0000;

  unfilter_scoreboard sb;
  int          src_idle_pct  = 34;
  int          snk_idle_pct  = 83;
  logic        squeeze_req   = 1'b0;
  logic        squeeze_taken = 1'b0;
  int          hold_left     = 0;
  int          cycle_count   = 0;

  png_row_unfilter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output side: check, random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        sb.check_word(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
      end
      if (squeeze_req && !squeeze_taken) begin
        squeeze_taken <= 1'b1;
        hold_left     <= 120;
        m_tready      <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic send_row(output int n);
    logic [7:0] fb;
    if ($urandom_range(99) < 6) fb = 8'($urandom_range(255, FILT_BAD_MIN));
    else fb = 8'($urandom_range(4));
    send_byte(fb);
    n = 1 + sb.row_len();
    for (int c = 0; c < sb.row_len(); c++) send_byte(8'($urandom));
  endtask

  task automatic send_image(output int n);
    int k;
    n = 0;
    for (int r = 0; r < sb.rows_total(); r++) begin
      send_row(k);
      n += k;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // upper data bits above each register's width are junk and must be ignored
  task automatic config_image(input logic [11:0] w, input logic [2:0] b,
                              input logic [15:0] r);
    cfg_write(REG_IMAGE_WIDTH, {4'($urandom), w});
    cfg_write(REG_BYTES_PER_PIXEL, {13'($urandom), b});
    cfg_write(REG_IMAGE_ROWS, r);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [11:0] w;
    case ($urandom_range(19))
      0:       w = 12'd0;
      1:       w = 12'($urandom_range(9, 16));
      default: w = 12'($urandom_range(1, 8));
    endcase
    config_image(w, 3'($urandom_range(7)), 16'($urandom_range(4)));
  endtask

  initial begin
    logic [7:0] warmup [$];
    int         n;
    int         rand_items;
    sb         = new();
    rand_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: one byte per row, one row per image
    warmup = '{FILT_PAETH, 8'hFF, FILT_BAD_MIN, 8'h80, 8'hFF, 8'h00};
    foreach (warmup[i]) send_byte(warmup[i]);
    drain();

    // two-byte rows through every filter type
    cfg_write(REG_UNUSED, 16'hFFFF);
    config_image(12'd2, 3'd1, 16'd5);
    warmup = '{FILT_NONE,  8'hFF, 8'h01,
               FILT_SUB,   8'h01, 8'hFF,
               FILT_UP,    8'h80, 8'h80,
               FILT_AVG,   8'hFF, 8'hFF,
               FILT_PAETH, 8'h7F, 8'h00};
    foreach (warmup[i]) send_byte(warmup[i]);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct = 34;
          snk_idle_pct = 83;
        end
        1: begin
          src_idle_pct = 83;
          snk_idle_pct = 34;
          // tallest image, cut short by lowering the row total between rows
          config_image(12'd1, 3'd1, 16'hFFFF);
          repeat (3) send_row(n);
          drain();
          cfg_write(REG_IMAGE_ROWS, 16'd1);
          cfg_valid <= 1'b0;
          send_row(n);
          drain();
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          // wide pixels clamped, with the output held off for a while
          config_image(12'd8, 3'd7, 16'd2);
          squeeze_req <= 1'b1;
          send_image(n);
          drain();
        end
      endcase
      while (rand_items < 180 * (mode + 1)) begin
        random_config();
        repeat ($urandom_range(1, 3)) begin
          if (rand_items < 180 * (mode + 1)) begin
            send_image(n);
            rand_items += n;
          end
        end
        drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
